FILE: rtl/e2q_pkg.sv
// Package with shared constants and the arctangent table for the Euler to quaternion block.
`timescale 1ns / 1ps
package e2q_pkg;

  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int QUAT_WIDTH_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int FRAC_BITS = 30;
  // Working width for the CORDIC and the products in Q30 (sign plus guard bits).
  localparam int WW = 34;

  localparam logic signed [WW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [WW-1:0] PI_HALF_Q30 = 34'sd1686629713;
  localparam logic signed [WW-1:0] GAIN_Q30    = 34'sd652032874;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGULAR_MINOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGULAR_MAJOR = 1'd1;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [WW-1:0] atan_q30(input logic [4:0] i);
    logic signed [WW-1:0] r;
    begin
      unique case (i)
        5'd0:  r = 34'sd843314857;
        5'd1:  r = 34'sd497837829;
        5'd2:  r = 34'sd263043837;
        5'd3:  r = 34'sd133525159;
        5'd4:  r = 34'sd67021687;
        5'd5:  r = 34'sd33543516;
        5'd6:  r = 34'sd16775851;
        5'd7:  r = 34'sd8388437;
        5'd8:  r = 34'sd4194283;
        5'd9:  r = 34'sd2097149;
        5'd10: r = 34'sd1048576;
        5'd11: r = 34'sd524288;
        5'd12: r = 34'sd262144;
        5'd13: r = 34'sd131072;
        5'd14: r = 34'sd65536;
        5'd15: r = 34'sd32768;
        5'd16: r = 34'sd16384;
        5'd17: r = 34'sd8192;
        5'd18: r = 34'sd4096;
        5'd19: r = 34'sd2048;
        5'd20: r = 34'sd1024;
        5'd21: r = 34'sd512;
        5'd22: r = 34'sd256;
        5'd23: r = 34'sd128;
        5'd24: r = 34'sd64;
        5'd25: r = 34'sd32;
        5'd26: r = 34'sd16;
        5'd27: r = 34'sd8;
        5'd28: r = 34'sd4;
        5'd29: r = 34'sd2;
        5'd30: r = 34'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Q30 product rounded back to Q30 (add half, floor).
  function automatic logic signed [WW-1:0] mul_q30(input logic signed [WW-1:0] a,
                                                   input logic signed [WW-1:0] b);
    logic signed [2*WW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< (FRAC_BITS - 1));
      return WW'(p >>> FRAC_BITS);
    end
  endfunction

endpackage

FILE: rtl/e2q_if.sv
// Valid/ready channel interface carrying one payload word.
`timescale 1ns / 1ps
interface e2q_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of a Q30 angle, one stage per register.
`timescale 1ns / 1ps
module e2q_cordic #(
  parameter int STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [e2q_pkg::WW-1:0]    ang_i,
  output logic signed [e2q_pkg::WW-1:0]    cos_o,
  output logic signed [e2q_pkg::WW-1:0]    sin_o
);
  localparam int W = e2q_pkg::WW;
  localparam int N = (STAGES > 32) ? 32 : STAGES;

  logic signed [W-1:0] x_r [N+1];
  logic signed [W-1:0] y_r [N+1];
  logic signed [W-1:0] z_r [N+1];
  logic                f_r [N+1];

  // Fold into [-pi/2, pi/2]; results are negated at the end.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= e2q_pkg::GAIN_Q30;
      y_r[0] <= '0;
      if (ang_i > e2q_pkg::PI_HALF_Q30) begin
        z_r[0] <= ang_i - e2q_pkg::PI_Q30;
        f_r[0] <= 1'b1;
      end else if (ang_i < -e2q_pkg::PI_HALF_Q30) begin
        z_r[0] <= ang_i + e2q_pkg::PI_Q30;
        f_r[0] <= 1'b1;
      end else begin
        z_r[0] <= ang_i;
        f_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - e2q_pkg::atan_q30(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + e2q_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  assign cos_o = f_r[N] ? -x_r[N] : x_r[N];
  assign sin_o = f_r[N] ? -y_r[N] : y_r[N];
endmodule

FILE: rtl/e2q_combine.sv
// Product and sum stages forming the four quaternion parts from half-angle sines and cosines.
`timescale 1ns / 1ps
module e2q_combine #(
  parameter int QUAT_WIDTH = e2q_pkg::QUAT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [e2q_pkg::WW-1:0]       cy_i, sy_i, cr_i, sr_i, cp_i, sp_i,
  output logic signed [QUAT_WIDTH-1:0]        w_o, x_o, y_o, z_o
);
  localparam int W   = e2q_pkg::WW;
  localparam int SH  = 32 - QUAT_WIDTH;
  localparam int SW  = W + 1;
  localparam logic signed [SW-1:0] LIM = SW'(1) <<< (QUAT_WIDTH - 2);

  // Stage 1: yaw by roll products.
  logic signed [W-1:0] cc_r, cs_r, sc_r, ss_r, cp1_r, sp1_r;
  // Stage 2: triple products.
  logic signed [W-1:0] t_r [8];
  // Stage 3: sums.
  logic signed [SW-1:0] s_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r  <= e2q_pkg::mul_q30(cy_i, cr_i);
      cs_r  <= e2q_pkg::mul_q30(cy_i, sr_i);
      sc_r  <= e2q_pkg::mul_q30(sy_i, cr_i);
      ss_r  <= e2q_pkg::mul_q30(sy_i, sr_i);
      cp1_r <= cp_i;
      sp1_r <= sp_i;
      t_r[0] <= e2q_pkg::mul_q30(cc_r, cp1_r);
      t_r[1] <= e2q_pkg::mul_q30(ss_r, sp1_r);
      t_r[2] <= e2q_pkg::mul_q30(cs_r, cp1_r);
      t_r[3] <= e2q_pkg::mul_q30(sc_r, sp1_r);
      t_r[4] <= e2q_pkg::mul_q30(cc_r, sp1_r);
      t_r[5] <= e2q_pkg::mul_q30(ss_r, cp1_r);
      t_r[6] <= e2q_pkg::mul_q30(sc_r, cp1_r);
      t_r[7] <= e2q_pkg::mul_q30(cs_r, sp1_r);
      s_r[0] <= SW'(t_r[0]) + SW'(t_r[1]);
      s_r[1] <= SW'(t_r[2]) - SW'(t_r[3]);
      s_r[2] <= SW'(t_r[4]) + SW'(t_r[5]);
      s_r[3] <= SW'(t_r[6]) - SW'(t_r[7]);
    end
  end

  function automatic logic signed [QUAT_WIDTH-1:0] to_quat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    begin
      if (SH > 0) r = (v + (SW'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
      else        r = v;
      if (r > LIM)  r = LIM;
      if (r < -LIM) r = -LIM;
      return QUAT_WIDTH'(r);
    end
  endfunction

  assign w_o = to_quat(s_r[0]);
  assign x_o = to_quat(s_r[1]);
  assign y_o = to_quat(s_r[2]);
  assign z_o = to_quat(s_r[3]);
endmodule

FILE: rtl/euler_to_quaternion.sv
// Top level of the pipelined Euler angle to quaternion converter.
//
//  channel | direction | word contents
//  in_     | sink      | roll_angle, pitch_angle, yaw_angle (signed Q3.13)
//  out_    | source    | quat_w/x/y/z (signed Q1.14), pitch_clipped
//  cfg_    | write     | singular_minor (index 0), singular_major (index 1)
//
// The pipeline holds the pitch clamp stage, one CORDIC fold stage, CORDIC_STAGES
// rotation stages, three product and sum stages and the output register.
// A new word is accepted in every cycle that the pipeline advances. All stages move
// together; while the output waits, every stage holds, so nothing is lost or repeated.
// Reset (rst_n, synchronous, active low) clears the valid bits and loads the thresholds.
`timescale 1ns / 1ps
module euler_to_quaternion #(
  parameter int ANGLE_WIDTH   = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int QUAT_WIDTH    = e2q_pkg::QUAT_WIDTH_DEF,
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ANGLE_WIDTH-1:0]    in_roll_angle,
  input  logic signed [ANGLE_WIDTH-1:0]    in_pitch_angle,
  input  logic signed [ANGLE_WIDTH-1:0]    in_yaw_angle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [QUAT_WIDTH-1:0]     out_quat_w,
  output logic signed [QUAT_WIDTH-1:0]     out_quat_x,
  output logic signed [QUAT_WIDTH-1:0]     out_quat_y,
  output logic signed [QUAT_WIDTH-1:0]     out_quat_z,
  output logic                             out_pitch_clipped,
  input  logic                             cfg_we,
  input  logic [e2q_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ANGLE_WIDTH-2:0]           cfg_data
);
  localparam int W     = e2q_pkg::WW;
  localparam int N     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  // Clamp stage, fold stage, N rotations, three arithmetic stages, output register.
  localparam int DEPTH = N + 6;
  localparam int AW    = ANGLE_WIDTH;
  localparam int TW    = AW - 1;

  logic [TW-1:0] minor_r, major_r;
  logic          adv;
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minor_r <= TW'(12861);
      major_r <= TW'(12875);
    end else if (cfg_we) begin
      unique case (cfg_index)
        e2q_pkg::REG_SINGULAR_MINOR: minor_r <= cfg_data;
        e2q_pkg::REG_SINGULAR_MAJOR: major_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output stage is empty or being drained.
  assign adv      = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_valid};
  end

  // Stage 0: pitch clamp out of the singular band; angles widened to Q30.
  logic [AW-1:0]   mag;
  logic            in_band, below_half;
  logic signed [AW-1:0] pitch_mv;
  always_comb begin
    mag        = in_pitch_angle[AW-1] ? AW'(-in_pitch_angle) : AW'(in_pitch_angle);
    in_band    = (mag > AW'(minor_r)) && (mag < AW'(major_r));
    below_half = (W'(mag) << (33 - AW)) < e2q_pkg::PI_HALF_Q30;
    pitch_mv   = below_half ? AW'(minor_r) : AW'(major_r);
    if (in_pitch_angle[AW-1]) pitch_mv = -pitch_mv;
  end

  logic signed [W-1:0] roll_r, pitch_r, yaw_r;
  logic                clip_r [DEPTH];
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r   <= W'(in_roll_angle) <<< (32 - AW);
      yaw_r    <= W'(in_yaw_angle) <<< (32 - AW);
      pitch_r  <= W'(in_band ? pitch_mv : in_pitch_angle) <<< (32 - AW);
      clip_r[0] <= in_band;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_clip
    always_ff @(posedge clk) if (adv) clip_r[k] <= clip_r[k-1];
  end

  logic signed [W-1:0] cy, sy, cr, sr, cp, sp;
  e2q_cordic #(.STAGES(N)) u_yaw   (.clk, .en(adv), .ang_i(yaw_r),   .cos_o(cy), .sin_o(sy));
  e2q_cordic #(.STAGES(N)) u_roll  (.clk, .en(adv), .ang_i(roll_r),  .cos_o(cr), .sin_o(sr));
  e2q_cordic #(.STAGES(N)) u_pitch (.clk, .en(adv), .ang_i(pitch_r), .cos_o(cp), .sin_o(sp));

  logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;
  e2q_combine #(.QUAT_WIDTH(QUAT_WIDTH)) u_comb (
    .clk, .en(adv),
    .cy_i(cy), .sy_i(sy), .cr_i(cr), .sr_i(sr), .cp_i(cp), .sp_i(sp),
    .w_o(qw), .x_o(qx), .y_o(qy), .z_o(qz)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_quat_w <= qw;
      out_quat_x <= qx;
      out_quat_y <= qy;
      out_quat_z <= qz;
    end
  end

  assign out_valid         = vld_r[DEPTH-1];
  assign out_pitch_clipped = clip_r[DEPTH-1];
endmodule

FILE: rtl/e2q_checker.sv
// Port-level checker for the Euler to quaternion converter, bound to the top level.
`timescale 1ns / 1ps
module e2q_checker #(
  parameter int QUAT_WIDTH = e2q_pkg::QUAT_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [QUAT_WIDTH-1:0]  out_quat_w
);
  localparam logic signed [QUAT_WIDTH-1:0] LIM = QUAT_WIDTH'(1) <<< (QUAT_WIDTH - 2);

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_w))
    else $error("output word changed under stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_w <= LIM) && (out_quat_w >= -LIM))
    else $error("quaternion part out of range");
endmodule

bind euler_to_quaternion e2q_checker #(.QUAT_WIDTH(QUAT_WIDTH)) u_e2q_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_quat_w
);

FILE: sim/tb_top.sv
// Self-checking testbench for the Euler angle to quaternion converter.
`timescale 1ns / 1ps
module tb_top;

  localparam int AW = e2q_pkg::ANGLE_WIDTH_DEF;
  localparam int QW = e2q_pkg::QUAT_WIDTH_DEF;
  localparam int STAGES = e2q_pkg::CORDIC_STAGES_DEF;
  // The pipeline is CORDIC_STAGES + 6 deep; the drain wait is longer than that.
  localparam int DRAIN_CYCLES = STAGES + 14;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint PI_Q = 64'sd3373259426;
  localparam longint PI_HALF_Q = 64'sd1686629713;
  localparam longint GAIN_Q = 64'sd652032874;

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
  } euler_word_t;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic                 clipped;
  } quat_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [e2q_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [AW-2:0] cfg_data;

  e2q_if #(.payload_t(euler_word_t)) euler_ch ();
  e2q_if #(.payload_t(quat_word_t))  quat_ch ();

  euler_to_quaternion u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (euler_ch.valid),
    .in_ready          (euler_ch.ready),
    .in_roll_angle     (euler_ch.data.roll),
    .in_pitch_angle    (euler_ch.data.pitch),
    .in_yaw_angle      (euler_ch.data.yaw),
    .out_valid         (quat_ch.valid),
    .out_ready         (quat_ch.ready),
    .out_quat_w        (quat_ch.data.w),
    .out_quat_x        (quat_ch.data.x),
    .out_quat_y        (quat_ch.data.y),
    .out_quat_z        (quat_ch.data.z),
    .out_pitch_clipped (quat_ch.data.clipped),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Words waiting to be driven, and quaternions predicted but not yet seen.
  euler_word_t angle_queue[$];
  quat_word_t  quat_expected[$];

  // The testbench copy of the two thresholds.
  longint thresh_minor;
  longint thresh_major;

  int  error_count;
  int  words_sent;
  int  words_checked;
  int  clipped_seen;
  int  cycle_count;
  bit  no_idle;
  bit  euler_fire;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor shift of a 64-bit signed value.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint a, longint b);
    return floor_shift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  // Half-angle sine and cosine in Q30 for one Q3.13 angle. Angles past
  // +/-pi/2 (half angle) are folded by pi and the results negated.
  function automatic void half_angle_trig(input longint ang, output longint s_out,
                                          output longint c_out);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    z = ang * (64'sd1 <<< (32 - AW));
    x = GAIN_Q;
    y = 0;
    flip = 1'b0;
    if (z > PI_HALF_Q) begin
      z -= PI_Q;
      flip = 1'b1;
    end else if (z < -PI_HALF_Q) begin
      z += PI_Q;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(e2q_pkg::atan_q30(5'(i)));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(e2q_pkg::atan_q30(5'(i)));
      end
    end
    c_out = flip ? -x : x;
    s_out = flip ? -y : y;
  endfunction

  // Round a Q30 sum to Q1.14 and saturate to plus or minus one.
  function automatic logic signed [QW-1:0] to_q14(longint v);
    longint r;
    longint lim;
    lim = 64'sd1 <<< (QW - 2);
    r = floor_shift(v + (64'sd1 <<< (32 - QW - 1)), 32 - QW);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return QW'(r);
  endfunction

  function automatic longint prod3(longint a, longint b, longint c);
    return round_q30(round_q30(a, b), c);
  endfunction

  // Expected quaternion for one word of angles under the current thresholds.
  function automatic quat_word_t predict_quat(euler_word_t a);
    quat_word_t q;
    longint pitch;
    longint mag;
    longint target;
    longint cy, sy, cr, sr, cp, sp;
    pitch = longint'(a.pitch);
    mag = (pitch < 0) ? -pitch : pitch;
    q.clipped = 1'b0;
    if (mag > thresh_minor && mag < thresh_major) begin
      target = (mag * (64'sd1 <<< (33 - AW)) < PI_HALF_Q) ? thresh_minor : thresh_major;
      pitch = (pitch > 0) ? target : -target;
      q.clipped = 1'b1;
    end
    half_angle_trig(longint'(a.yaw), sy, cy);
    half_angle_trig(longint'(a.roll), sr, cr);
    half_angle_trig(pitch, sp, cp);
    q.w = to_q14(prod3(cy, cr, cp) + prod3(sy, sr, sp));
    q.x = to_q14(prod3(cy, sr, cp) - prod3(sy, cr, sp));
    q.y = to_q14(prod3(cy, cr, sp) + prod3(sy, sr, cp));
    q.z = to_q14(prod3(sy, cr, cp) - prod3(cy, sr, sp));
    return q;
  endfunction

  // Input driver. A word stays on the bus until it is taken; a new one (or an
  // idle cycle) is chosen only after a handshake or while the bus is idle.
  always @(negedge clk) begin
    euler_word_t nxt;
    bit          go;
    if (!rst_n) begin
      euler_ch.valid <= 1'b0;
      euler_ch.data  <= '0;
    end else if (!euler_ch.valid || euler_fire) begin
      go = (angle_queue.size() != 0) && (no_idle || $urandom_range(99) >= 22);
      if (go) begin
        nxt = angle_queue.pop_front();
        euler_ch.data  <= nxt;
        euler_ch.valid <= 1'b1;
      end else begin
        euler_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      quat_ch.ready <= 1'b0;
    end else begin
      quat_ch.ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  // Every accepted word of angles gets its expected quaternion queued at
  // the same edge. The threshold copy only changes while the block is idle.
  always @(posedge clk) begin
    euler_fire <= rst_n && euler_ch.valid && euler_ch.ready;
    if (rst_n && euler_ch.valid && euler_ch.ready) begin
      quat_expected.push_back(predict_quat(euler_ch.data));
      words_sent++;
    end
  end

  // Result checker: each taken quaternion is compared with the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    quat_word_t want;
    if (rst_n && quat_ch.valid && quat_ch.ready) begin
      if (quat_expected.size() == 0) begin
        $error("quaternion word with nothing expected: %p", quat_ch.data);
        error_count++;
      end else begin
        want = quat_expected.pop_front();
        words_checked++;
        if (quat_ch.data.clipped) clipped_seen++;
        if (quat_ch.data.w !== want.w) begin
          $error("quat_w expected %0d actual %0d", want.w, quat_ch.data.w);
          error_count++;
        end
        if (quat_ch.data.x !== want.x) begin
          $error("quat_x expected %0d actual %0d", want.x, quat_ch.data.x);
          error_count++;
        end
        if (quat_ch.data.y !== want.y) begin
          $error("quat_y expected %0d actual %0d", want.y, quat_ch.data.y);
          error_count++;
        end
        if (quat_ch.data.z !== want.z) begin
          $error("quat_z expected %0d actual %0d", want.z, quat_ch.data.z);
          error_count++;
        end
        if (quat_ch.data.clipped !== want.clipped) begin
          $error("pitch_clipped expected %0d actual %0d", want.clipped,
                 quat_ch.data.clipped);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Threshold write; only called while the pipeline is empty.
  task automatic write_threshold(logic [e2q_pkg::CFG_IDX_W-1:0] idx, logic [AW-2:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == e2q_pkg::REG_SINGULAR_MINOR) thresh_minor = longint'(value);
    else thresh_major = longint'(value);
  endtask

  task automatic set_thresholds(int minor_val, int major_val);
    write_threshold(e2q_pkg::REG_SINGULAR_MINOR, (AW-1)'(minor_val));
    write_threshold(e2q_pkg::REG_SINGULAR_MAJOR, (AW-1)'(major_val));
  endtask

  // Wait until every queued word has gone through and the pipeline drained.
  task automatic drain_pipeline();
    while (angle_queue.size() != 0 || euler_ch.valid || quat_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [AW-1:0] pick_angle();
    return AW'($urandom_range(65535));
  endfunction

  // Pitch values near the singular band in 45 of 100 draws so clamp and snap both occur,
  // the rest spread over the whole input range.
  function automatic logic signed [AW-1:0] pick_pitch();
    int lo;
    int hi;
    int mag;
    lo = int'(thresh_minor) - 24;
    hi = int'(thresh_major) + 24;
    if (lo < 0) lo = 0;
    if (hi > 32767) hi = 32767;
    if (lo > hi) lo = hi;
    if ($urandom_range(99) < 45) begin
      mag = $urandom_range(hi, lo);
      if ($urandom_range(1)) mag = 12868 - 3 + $urandom_range(6);
      return $urandom_range(1) ? AW'(-mag) : AW'(mag);
    end
    return pick_angle();
  endfunction

  task automatic queue_angles(int r, int p, int y);
    euler_word_t a;
    a.roll  = AW'(r);
    a.pitch = AW'(p);
    a.yaw   = AW'(y);
    angle_queue.push_back(a);
  endtask

  task automatic queue_random(int count);
    euler_word_t a;
    for (int i = 0; i < count; i++) begin
      a.roll  = pick_angle();
      a.pitch = pick_pitch();
      a.yaw   = pick_angle();
      angle_queue.push_back(a);
    end
  endtask

  initial begin
    int mn;
    error_count   = 0;
    words_sent    = 0;
    words_checked = 0;
    clipped_seen  = 0;
    cycle_count   = 0;
    no_idle       = 1'b0;
    euler_fire    = 1'b0;
    thresh_minor  = 12861;
    thresh_major  = 12875;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = e2q_pkg::REG_SINGULAR_MINOR;
    cfg_data  = '0;
    euler_ch.valid = 1'b0;
    euler_ch.data  = '0;
    quat_ch.ready  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset thresholds: zero, range extremes, the
    // full input range beyond pi, pitch on each threshold (open band, no
    // move), pitch inside the band on both sides of pi/2, and negative pitch.
    queue_angles(0, 0, 0);
    queue_angles(25736, 25736, 25736);
    queue_angles(-25736, -25736, -25736);
    queue_angles(32767, 0, -32768);
    queue_angles(-32768, 32767, 32767);
    queue_angles(0, -32768, 0);
    queue_angles(12868, 0, -12868);
    queue_angles(1000, 12861, -2000);
    queue_angles(1000, 12875, -2000);
    queue_angles(-3000, -12861, 4000);
    queue_angles(-3000, -12875, 4000);
    queue_angles(500, 12862, 500);
    queue_angles(500, 12867, 500);
    queue_angles(500, 12868, 500);
    queue_angles(500, 12874, 500);
    queue_angles(-700, -12862, 900);
    queue_angles(-700, -12867, 900);
    queue_angles(-700, -12868, 900);
    queue_angles(-700, -12874, 900);
    queue_angles(6434, 6434, 6434);
    drain_pipeline();

    // Random phases over several threshold settings, including both
    // extremes and the reversed order in which nothing is moved. One
    // phase runs with no idling on either side.
    queue_random(110);
    drain_pipeline();

    set_thresholds(0, 25736);
    no_idle = 1'b1;
    queue_random(100);
    drain_pipeline();
    no_idle = 1'b0;

    set_thresholds(25736, 0);
    queue_random(90);
    drain_pipeline();

    set_thresholds(25736, 25736);
    queue_random(70);
    drain_pipeline();

    set_thresholds(0, 0);
    queue_random(70);
    drain_pipeline();

    set_thresholds(12000, 13800);
    queue_random(110);
    drain_pipeline();

    set_thresholds(12867, 12868);
    queue_random(70);
    drain_pipeline();

    for (int k = 0; k < 3; k++) begin
      mn = $urandom_range(25736);
      set_thresholds(mn, $urandom_range(25736, mn));
      queue_random(45);
      drain_pipeline();
    end

    $display("Converted %0d angle words, checked %0d quaternions (%0d with pitch clipped)",
             words_sent, words_checked, clipped_seen);
    $display("across ten threshold settings, with random stalls on both channels.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: euler_to_quaternion.f
rtl/e2q_pkg.sv
rtl/e2q_if.sv
rtl/e2q_cordic.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
rtl/e2q_checker.sv
sim/tb_top.sv
